// ===== hw/rtl/swbd_pkg.sv =====
// ----------------------------------------------------------------------------
// swbd_pkg
// Shared types and constants for the bit-aligned sync word deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package swbd_pkg;

  localparam int unsigned CfgAddrWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgAddrWidth-1:0] RegSyncPattern  = 2'd0;
  localparam logic [CfgAddrWidth-1:0] RegSyncTwoBytes = 2'd1;
  localparam logic [CfgAddrWidth-1:0] RegDataLength   = 2'd2;
  localparam logic [CfgAddrWidth-1:0] RegCheckMode    = 2'd3;

  localparam logic [7:0]  DataLengthReset = 8'd16;

  localparam logic [31:0] MaskOneByte = 32'h00ff_0000;
  localparam logic [31:0] MaskTwoByte = 32'hffff_0000;

  typedef struct packed {
    logic       found;
    logic [2:0] offset;
    logic [7:0] frame_data;
  } swbd_ext_t;

endpackage : swbd_pkg

`default_nettype wire

// ===== hw/rtl/swbd_extract.sv =====
// ----------------------------------------------------------------------------
// swbd_extract
// Sync word search over all eight bit positions and aligned byte extraction.
// ----------------------------------------------------------------------------
`default_nettype none

module swbd_extract import swbd_pkg::*; (
  input  wire logic [15:0] window_i,
  input  wire logic [7:0]  raw_byte_i,
  input  wire logic [2:0]  offset_i,
  input  wire logic [15:0] sync_pattern_i,
  input  wire logic        sync_is_two_bytes_i,
  output swbd_ext_t        ext_o
);

  logic [23:0] stream;
  logic [31:0] word;
  logic [31:0] mask;
  logic [31:0] pattern;

  assign stream  = {window_i, raw_byte_i};
  assign word    = {stream, 8'h00};
  assign mask    = sync_is_two_bytes_i ? MaskTwoByte : MaskOneByte;
  assign pattern = sync_is_two_bytes_i ? {sync_pattern_i, 16'h0000}
                                       : {8'h00, sync_pattern_i[7:0], 16'h0000};

  // The earliest bit position wins, which is the highest remaining offset.
  always_comb begin
    ext_o.found      = 1'b0;
    ext_o.offset     = 3'd0;
    ext_o.frame_data = stream[offset_i +: 8];
    for (int k = 0; k < 8; k++) begin
      if (((word << (8 - k)) & mask) == pattern) begin
        ext_o.found  = 1'b1;
        ext_o.offset = 3'(k);
      end
    end
  end

endmodule : swbd_extract

`default_nettype wire

// ===== hw/rtl/sync_word_bit_deframer_core.sv =====
// ----------------------------------------------------------------------------
// sync_word_bit_deframer_core
// Finds a sync word at any bit offset and streams the bit-aligned frame.
// ----------------------------------------------------------------------------
// Raw bytes enter on the input channel (in_valid_i / in_stall_o), earliest
// bit in bit 7. While hunting, each item is searched for the 8- or 16-bit
// sync word at all eight bit positions and yields no result. Once found,
// every later item yields one aligned frame byte on the output channel
// (out_valid_o / out_stall_i) with first and last marks; check_ok_o is
// meaningful with last.
// One item is accepted every cycle unless stalled. A result is registered
// in the cycle after its item is accepted. The single output register sets
// the rate: a result held by a stalling receiver stalls the input.
// Reset clears the search window, returns the block to hunting and loads the
// register defaults (data length 16, one-byte sync word 0, no check byte).
// Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i and
// takes effect at once; it should only be changed while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_bit_deframer_core import swbd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [7:0]              raw_byte_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [7:0]                   frame_byte_o,
  output logic                         first_o,
  output logic                         last_o,
  output logic                         check_ok_o
);

  logic [15:0] sync_pattern_q;
  logic        sync_is_two_bytes_q;
  logic [7:0]  data_length_q;
  logic        check_mode_q;

  logic [15:0] window_q, window_d;
  logic        collecting_q, collecting_d;
  logic [2:0]  offset_q, offset_d;
  logic [8:0]  taken_q, taken_d;
  logic [7:0]  xor_q, xor_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  frame_byte_q;
  logic        first_q, last_q, check_ok_q;

  logic        accept;
  logic        emit;
  logic [8:0]  taken_next;
  logic [8:0]  total;
  logic [7:0]  xor_next;
  logic        frame_end;
  swbd_ext_t   ext;

  swbd_extract u_extract (
    .window_i            (window_q),
    .raw_byte_i          (raw_byte_i),
    .offset_i            (offset_q),
    .sync_pattern_i      (sync_pattern_q),
    .sync_is_two_bytes_i (sync_is_two_bytes_q),
    .ext_o               (ext)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign emit       = accept & collecting_q;

  assign taken_next = taken_q + 9'd1;
  assign total      = {1'b0, data_length_q} + {8'd0, check_mode_q};
  assign xor_next   = xor_q ^ ext.frame_data;
  assign frame_end  = taken_next >= total;

  always_comb begin
    window_d     = window_q;
    collecting_d = collecting_q;
    offset_d     = offset_q;
    taken_d      = taken_q;
    xor_d        = xor_q;
    if (accept) begin
      window_d = {window_q[7:0], raw_byte_i};
      if (!collecting_q) begin
        if (ext.found) begin
          collecting_d = 1'b1;
          offset_d     = ext.offset;
          taken_d      = 9'd0;
          xor_d        = 8'd0;
        end
      end else begin
        xor_d = xor_next;
        if (frame_end) begin
          collecting_d = 1'b0;
          offset_d     = 3'd0;
          taken_d      = 9'd0;
        end else begin
          taken_d = taken_next;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pattern_q      <= 16'd0;
      sync_is_two_bytes_q <= 1'b0;
      data_length_q       <= DataLengthReset;
      check_mode_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegSyncPattern:  sync_pattern_q      <= cfg_wdata_i;
        RegSyncTwoBytes: sync_is_two_bytes_q <= cfg_wdata_i[0];
        RegDataLength:   data_length_q       <= cfg_wdata_i[7:0];
        RegCheckMode:    check_mode_q        <= cfg_wdata_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= 16'd0;
      collecting_q <= 1'b0;
      offset_q     <= 3'd0;
      taken_q      <= 9'd0;
      xor_q        <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      window_q     <= window_d;
      collecting_q <= collecting_d;
      offset_q     <= offset_d;
      taken_q      <= taken_d;
      xor_q        <= xor_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_byte_q <= ext.frame_data;
      first_q      <= (taken_q == 9'd0);
      last_q       <= frame_end;
      check_ok_q   <= frame_end & (~check_mode_q | (xor_next == 8'd0));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = frame_byte_q;
  assign first_o      = first_q;
  assign last_o       = last_q;
  assign check_ok_o   = check_ok_q;

endmodule : sync_word_bit_deframer_core

`default_nettype wire

// ===== hw/rtl/swbd_checker.sv =====
// ----------------------------------------------------------------------------
// swbd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] frame_byte_o,
  input wire logic       first_o,
  input wire logic       last_o,
  input wire logic       check_ok_o
);

  // A result held by the receiver stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o) &&
      $stable(first_o) && $stable(last_o) && $stable(check_ok_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && check_ok_o |-> last_o)
    else $error("check_ok without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while the result is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted item");

endmodule : swbd_checker

bind sync_word_bit_deframer_core swbd_checker u_swbd_checker (.*);

`default_nettype wire

// ===== tb/sync_word_bit_deframer_core_tb.sv =====
// ----------------------------------------------------------------------------
// sync_word_bit_deframer_core_tb
// Self-checking bench for the bit-aligned sync word deframer.
// ----------------------------------------------------------------------------
// Raw bytes are built as a bit stream: sync words at every bit offset,
// payloads with good and corrupted XOR check bytes, short frames and noise.
// Each accepted item is run through a local deframing model, and every frame
// byte that comes out is compared field by field with the oldest prediction.
// The run walks through a series of register settings, including zero and
// maximum frame lengths, both sync word sizes and both check modes, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_bit_deframer_core_tb import swbd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CheckNone = 1'b0;
  localparam logic CheckXor  = 1'b1;
  localparam int   CycleLimit = 400000;
  localparam int   NumPhases  = 12;
  localparam int   PhaseBytes = 140;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       ok;
  } frame_out_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr = '0;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              raw_byte = 8'h00;
  logic                    out_valid_o;
  logic                    out_stall = 1'b0;
  logic [7:0]              frame_byte_o;
  logic                    first_o;
  logic                    last_o;
  logic                    check_ok_o;

  sync_word_bit_deframer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .raw_byte_i  (raw_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .frame_byte_o(frame_byte_o),
    .first_o     (first_o),
    .last_o      (last_o),
    .check_ok_o  (check_ok_o)
  );

  // Register copies and deframer state of the local model.
  logic [15:0] sync_word_m  = 16'h0000;
  logic        two_bytes_m  = 1'b0;
  logic [7:0]  data_len_m   = DataLengthReset;
  logic        check_mode_m = CheckNone;
  logic [31:0] window_m     = 32'h0;
  logic        collecting_m = 1'b0;
  logic [2:0]  offset_m     = 3'd0;
  logic [8:0]  taken_m      = 9'd0;
  logic [7:0]  xor_m        = 8'h00;

  logic [7:0]  raw_stream_q[$];
  bit          stream_bits_q[$];
  frame_out_t  due_bytes_q[$];

  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int stall_nxt;
  int cycle_cnt = 0;
  int bytes_built = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int frames_done = 0;
  int bad_checks = 0;
  int errors = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic deframe_predict(input logic [7:0] raw);
    logic [31:0] w;
    logic [31:0] mask;
    logic [31:0] pat;
    logic [8:0]  total;
    logic        hit;
    frame_out_t  res;
    int          k;
    w = window_m | {16'h0000, raw, 8'h00};
    if (!collecting_m) begin
      mask = two_bytes_m ? MaskTwoByte : MaskOneByte;
      pat = two_bytes_m ? {sync_word_m, 16'h0000} : {8'h00, sync_word_m[7:0], 16'h0000};
      hit = 1'b0;
      for (k = 7; k >= 0; k--) begin
        if (!hit) begin
          w = w << 1;
          if ((w & mask) == pat) begin
            w = w << k;
            hit = 1'b1;
            collecting_m = 1'b1;
            offset_m = 3'(k);
            taken_m = 9'd0;
            xor_m = 8'h00;
          end
        end
      end
    end else begin
      res.data = 8'(w >> (8 + offset_m));
      res.first = (taken_m == 9'd0);
      res.last = 1'b0;
      res.ok = 1'b0;
      total = {1'b0, data_len_m} + {8'd0, check_mode_m};
      w = w << 8;
      taken_m = taken_m + 9'd1;
      xor_m = xor_m ^ res.data;
      if (taken_m >= total) begin
        res.last = 1'b1;
        res.ok = (check_mode_m == CheckXor) ? (xor_m == 8'h00) : 1'b1;
        collecting_m = 1'b0;
        offset_m = 3'd0;
        taken_m = 9'd0;
      end
      due_bytes_q.push_back(res);
    end
    window_m = w;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        deframe_predict(raw_byte);
        bytes_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (raw_stream_q.size() != 0) begin
          in_valid <= 1'b1;
          raw_byte <= raw_stream_q.pop_front();
          gap_left <= tx_gaps_on ? int'($urandom_range(10, 0)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic check_frame_byte();
    frame_out_t want;
    results_seen++;
    if (last_o) begin
      frames_done++;
      if (!check_ok_o) bad_checks++;
    end
    if (due_bytes_q.size() == 0) begin
      $display("%0t: unexpected frame byte, expected none actual %0h first %0b last %0b ok %0b",
               $time, frame_byte_o, first_o, last_o, check_ok_o);
      errors++;
    end else begin
      want = due_bytes_q.pop_front();
      check_field("frame_byte", want.data, frame_byte_o);
      check_field("first", {7'd0, want.first}, {7'd0, first_o});
      check_field("last", {7'd0, want.last}, {7'd0, last_o});
      check_field("check_ok", {7'd0, want.ok}, {7'd0, check_ok_o});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_nxt = stall_left;
      if (out_valid_o && !out_stall) begin
        check_frame_byte();
        stall_nxt = rx_stalls_on ? int'($urandom_range(10, 0)) : 0;
      end else if (out_valid_o && stall_nxt != 0) begin
        stall_nxt = stall_nxt - 1;
      end
      stall_left <= stall_nxt;
      out_stall <= (stall_nxt != 0);
    end
  end

  task automatic push_bits(input logic [15:0] value, input int nbits);
    logic [7:0] b;
    int i;
    for (i = nbits - 1; i >= 0; i--) stream_bits_q.push_back(value[i]);
    while (stream_bits_q.size() >= 8) begin
      for (i = 7; i >= 0; i--) b[i] = stream_bits_q.pop_front();
      raw_stream_q.push_back(b);
      bytes_built++;
    end
  endtask

  task automatic pad_stream();
    while (stream_bits_q.size() != 0) push_bits(16'($urandom), 1);
  endtask

  // Sync word at the current setting, then payload and optional check byte.
  task automatic push_frame(input int prefix, input logic [15:0] prefix_bits,
                            input int payload, input bit good_check);
    logic [7:0] acc;
    logic [7:0] d;
    int i;
    acc = 8'h00;
    push_bits(prefix_bits, prefix);
    if (two_bytes_m) push_bits(sync_word_m, 16);
    else push_bits({8'h00, sync_word_m[7:0]}, 8);
    for (i = 0; i < payload; i++) begin
      d = 8'($urandom);
      acc ^= d;
      push_bits({8'h00, d}, 8);
    end
    if (check_mode_m == CheckXor) begin
      if (!good_check) acc ^= 8'($urandom_range(255, 1));
      push_bits({8'h00, acc}, 8);
    end
  endtask

  task automatic cfg_write(input logic [CfgAddrWidth-1:0] addr, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
  endtask

  task automatic set_config(input logic [15:0] sync, input logic two, input logic [7:0] len,
                            input logic mode);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_write(RegSyncPattern, sync);
    cfg_write(RegSyncTwoBytes, {junk[15:1], two});
    cfg_write(RegDataLength, {junk[7:0], len});
    cfg_write(RegCheckMode, {junk[14:0], mode});
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sync_word_m = sync;
    two_bytes_m = two;
    data_len_m = len;
    check_mode_m = mode;
  endtask

  // Hold off until every item is in and every frame byte is out.
  task automatic drain();
    pad_stream();
    while (raw_stream_q.size() != 0 || in_valid || due_bytes_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int budget);
    int start;
    int kind;
    int full;
    int i;
    start = bytes_built;
    full = (data_len_m == 8'd0 && check_mode_m == CheckNone) ? 1 : int'(data_len_m);
    while (bytes_built - start < budget) begin
      kind = $urandom_range(9, 0);
      if (kind < 8) begin
        push_frame($urandom_range(12, 0), 16'($urandom), full, 1'b1);
      end else if (kind == 8) begin
        push_frame($urandom_range(12, 0), 16'($urandom), $urandom_range(full, 0), 1'b0);
      end else begin
        for (i = $urandom_range(6, 1); i > 0; i--) push_bits(16'($urandom), 8);
      end
    end
    drain();
  endtask

  initial begin
    logic [15:0] sync;
    logic        two;
    logic [7:0]  len;
    logic        mode;
    int          p;
    int          i;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-byte frames after a sync word at each of the eight bit offsets.
    set_config(16'h3CA5, 1'b0, 8'd0, CheckNone);
    for (i = 0; i < 8; i++) begin
      push_bits(16'h0000, i);
      push_bits(16'h00A5, 8);
      push_bits(i[0] ? 16'h0000 : 16'h00FF, 8);
    end
    drain();

    // All-ones two-byte sync word with a good and a corrupted check byte.
    set_config(16'hFFFF, 1'b1, 8'd2, CheckXor);
    push_bits(16'h0000, 3);
    push_bits(16'hFFFF, 16);
    push_bits(16'h00FF, 16);
    push_bits(16'h00FF, 8);
    push_bits(16'hFFFF, 16);
    push_bits(16'h5A00, 16);
    push_bits(16'h0000, 8);
    drain();

    for (p = 0; p < NumPhases; p++) begin
      sync = 16'($urandom);
      two = 1'($urandom);
      mode = 1'($urandom);
      len = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(40, 1)) : 8'($urandom_range(8, 1));
      case (p)
        0: begin
          two = 1'b1;
          len = 8'd255;
          mode = CheckXor;
        end
        1: begin
          sync = {sync[15:8], 8'h00};
          two = 1'b0;
          len = 8'd1;
          mode = CheckNone;
        end
        2: begin
          len = 8'd0;
          mode = CheckNone;
        end
        3: begin
          len = 8'd0;
          mode = CheckXor;
        end
        4: begin
          sync = 16'hFFFF;
          two = 1'b1;
        end
        5: begin
          sync = 16'h0000;
          two = 1'b1;
        end
        default: ;
      endcase
      tx_gaps_on = ($urandom_range(2, 0) != 0);
      rx_stalls_on = ($urandom_range(2, 0) != 0);
      set_config(sync, two, len, mode);
      random_phase(PhaseBytes);
    end

    repeat (10) @(posedge clk_i);
    if (due_bytes_q.size() != 0) begin
      $display("%0t: %0d frame bytes never arrived", $time, due_bytes_q.size());
      errors++;
    end
    $display("Sent %0d raw bytes over %0d register settings; checked %0d frame bytes.",
             bytes_sent, NumPhases + 2, results_seen);
    $display("Closed %0d frames, %0d with a failed check; %0d mismatches.",
             frames_done, bad_checks, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : sync_word_bit_deframer_core_tb

`default_nettype wire

// ===== filelist.f =====
hw/rtl/swbd_pkg.sv
hw/rtl/swbd_extract.sv
hw/rtl/sync_word_bit_deframer_core.sv
hw/rtl/swbd_checker.sv
tb/sync_word_bit_deframer_core_tb.sv
